// ===== sv/bbpe_pkg.sv =====
// Shared types, register map and default sizes for the boundary pixel extractor.
`default_nettype none

package bbpe_pkg;

    // Default frame limits (row store depth and row count range)
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    // Register map: index into the register list, byte address is 4 * index
    localparam int          CFG_AW       = 4;
    localparam logic [1:0]  REG_WIDTH    = 2'd0;
    localparam logic [1:0]  REG_HEIGHT   = 2'd1;
    localparam logic [1:0]  REG_MODE     = 2'd2;

    // Register reset values
    localparam logic [10:0] RST_WIDTH    = 11'd640;
    localparam logic [10:0] RST_HEIGHT   = 11'd480;
    localparam logic        RST_INNER    = 1'b0;

    // Stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int COORD_W   = 10;

    // Register contents handed from the config block to the datapath
    typedef struct packed {
        logic [10:0] width;
        logic [10:0] height;
        logic        inner;
    } t_cfg;

endpackage : bbpe_pkg

`default_nettype wire

// ===== sv/binary_boundary_pixel_extractor.sv =====
// Top level of the binary mask boundary pixel extractor.
`default_nettype none

// Takes one mask pixel per clock in raster order (bit 0 of s_axis_tdata) and
// sustains one pixel per cycle unless the output stalls; the limit is the single
// read and single write port of the line store, which each pixel uses once. A
// pixel's result, if any, passes from the stage 1 register into the output
// register, which holds it until it is taken. Results name the
// 4-connected boundary pixel one column left and one row above the pixel just
// taken, so only interior pixels are ever reported. The last pixel of a frame
// always yields a beat with tlast set, with found clear and zero coordinates
// when it has no boundary pixel of its own. The line store has no reset and
// needs no clearing pass: the first two rows of a frame after reset only feed
// the window. Write the registers only while the block is idle. Sizes below 3
// are taken as 3 and sizes above MAX_COLS / MAX_ROWS as those limits.

module binary_boundary_pixel_extractor
    import bbpe_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // APB configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [CFG_AW-1:0]    paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // Pixel stream in
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [0] filled, [7:1] zero
    // Boundary stream out
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // [9:0] col, [19:10] row, [23:20] zero
    output logic                      m_axis_tlast,   // frame_done
    output logic                      m_axis_tuser    // found
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    t_cfg cfg;

    bbpe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------------------------------------------------------
    // Last column / last row index from the clamped frame size
    // ---------------------------------------------------------------
    logic [31:0]   w32, h32;
    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;

    assign w32 = 32'(cfg.width);
    assign h32 = 32'(cfg.height);

    always_comb begin
        if (w32 < 32'd3)                  col_last = CW'(2);
        else if (w32 > 32'(MAX_COLS))     col_last = CW'(MAX_COLS - 1);
        else                              col_last = CW'(w32 - 32'd1);
        if (h32 < 32'd3)                  row_last = RW'(2);
        else if (h32 > 32'(MAX_ROWS))     row_last = RW'(MAX_ROWS - 1);
        else                              row_last = RW'(h32 - 32'd1);
    end

    // ---------------------------------------------------------------
    // Handshake and pipeline advance
    // ---------------------------------------------------------------
    logic r_s1_vld;
    logic r_o_vld;
    logic s1_adv;
    logic in_acc;

    assign s1_adv        = r_s1_vld & (~r_o_vld | m_axis_tready);
    assign s_axis_tready = ~r_s1_vld | s1_adv;
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    // ---------------------------------------------------------------
    // Stage 0: raster counters, line store read at the current column
    // ---------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          last_col, last_pix;

    assign last_col = (r_col >= col_last);
    assign last_pix = last_col & (r_row >= row_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_pix ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Stage 1 holding register for the pixel whose store entry is being read
    logic          r_s1_px;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_judge;
    logic          r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px    <= s_axis_tdata[0];
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_judge <= (r_col >= CW'(2)) & (r_row >= RW'(2));
            r_s1_last  <= last_pix;
        end
    end

    // ---------------------------------------------------------------
    // Line store: read at accept, write back when stage 1 moves on.
    // The pending write is always to the previous column, never the
    // column read in the same cycle (rows are at least 3 wide).
    // ---------------------------------------------------------------
    logic [1:0] mem_rd;
    logic       top_px, mid_px;

    bbpe_line_mem #(
        .DEPTH (MAX_COLS)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (mem_rd),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({mid_px, r_s1_px})
    );

    assign top_px = mem_rd[1];
    assign mid_px = mem_rd[0];

    // ---------------------------------------------------------------
    // Stage 1: 3x3 window shift and boundary test on the centre
    // ---------------------------------------------------------------
    logic [8:0] r_win, n_win;
    logic       centre, any_set, all_set, found, has_res;
    logic [CW-1:0] col_m1;
    logic [RW-1:0] row_m1;
    logic [31:0]   col_ext, row_ext;

    assign n_win   = {r_win[5:0], r_s1_px, mid_px, top_px};
    assign centre  = n_win[4];
    assign any_set = n_win[1] | n_win[3] | n_win[5] | n_win[7];
    assign all_set = n_win[1] & n_win[3] & n_win[5] & n_win[7];

    always_comb begin
        if (cfg.inner) found = r_s1_judge & centre & ~all_set;
        else           found = r_s1_judge & ~centre & any_set;
    end

    assign has_res = found | r_s1_last;
    assign col_m1  = r_s1_col - CW'(1);
    assign row_m1  = r_s1_row - RW'(1);
    assign col_ext = 32'(col_m1);
    assign row_ext = 32'(row_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_adv) begin
            r_win <= n_win;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] r_o_col, r_o_row;
    logic               r_o_found, r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv) begin
            r_o_vld <= has_res;
        end else if (m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && has_res) begin
            r_o_col   <= found ? col_ext[COORD_W-1:0] : '0;
            r_o_row   <= found ? row_ext[COORD_W-1:0] : '0;
            r_o_found <= found;
            r_o_last  <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {4'd0, r_o_row, r_o_col};
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_found;

endmodule : binary_boundary_pixel_extractor

`default_nettype wire

// ===== sv/bbpe_cfg.sv =====
// APB register block: frame width, frame height and boundary mode.
`default_nettype none

module bbpe_cfg
    import bbpe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic       wr_hit;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_hit  = psel & penable & pwrite & pready;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.inner  <= RST_INNER;
        end else if (wr_hit) begin
            case (reg_idx)
                REG_WIDTH:  r_cfg.width  <= pwdata[10:0];
                REG_HEIGHT: r_cfg.height <= pwdata[10:0];
                REG_MODE:   r_cfg.inner  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = {21'd0, r_cfg.width};
            REG_HEIGHT: prdata = {21'd0, r_cfg.height};
            REG_MODE:   prdata = {31'd0, r_cfg.inner};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule : bbpe_cfg

`default_nettype wire

// ===== sv/bbpe_line_mem.sv =====
// Two-row line store: one entry per column holds {row two above, row one above}.
`default_nettype none

module bbpe_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [1:0]         o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [1:0]    i_wr_data
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : bbpe_line_mem

`default_nettype wire

// ===== sv/bbpe_checker.sv =====
// Port-level checks for the boundary pixel extractor, bound to the top level.
`default_nettype none

module bbpe_checker
    import bbpe_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] i_m_tdata,
    input wire logic                 i_m_tlast,
    input wire logic                 i_m_tuser
);

    // A beat without a boundary pixel only closes a frame
    a_nofound_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> i_m_tlast)
        else $error("result beat without found or frame_done");

    // Frame-end beat without a boundary pixel carries zero coordinates
    a_nofound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> i_m_tdata == '0)
        else $error("coordinates set on a beat without found");

    // Reported pixels are interior: never on column 0 or row 0
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |->
            i_m_tdata[9:0] != 10'd0 && i_m_tdata[19:10] != 10'd0 && i_m_tdata[23:20] == 4'd0)
        else $error("boundary pixel on the frame border or padding set");

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast) && $stable(i_m_tuser))
        else $error("output beat changed while stalled");

endmodule : bbpe_checker

bind binary_boundary_pixel_extractor bbpe_checker u_bbpe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== test/tb_binary_boundary_pixel_extractor.sv =====
// Self-checking testbench for the binary mask boundary pixel extractor.
`timescale 1ns / 100ps

module tb_binary_boundary_pixel_extractor;
    import bbpe_pkg::*;

    localparam int QUIET_LIMIT  = 4000;   // cycles with no beat on either side
    localparam int STALL_CYCLES = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;      // settle margin after the last expected beat
    localparam int PHASE_PIXELS = 40;     // random pixels per traffic phase

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               found;
        logic               frame_done;
    } t_boundary;

    typedef enum logic [2:0] {
        PAT_EMPTY, PAT_FULL, PAT_CHECKER, PAT_BLOB, PAT_NOISE
    } t_mask_pattern;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // APB
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Streams
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [0] filled, [7:1] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [9:0] col, [19:10] row, [23:20] zero
    logic                 m_axis_tlast;        // frame_done
    logic                 m_axis_tuser;        // found

    binary_boundary_pixel_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Stimulus and expectation stores
    logic      pix_q[$];
    t_boundary boundary_q[$];

    // Traffic control shared with the initial block
    int   tx_idle_pct = 38;
    int   rx_idle_pct = 49;
    logic tx_pause    = 1'b0;
    int   stall_kick  = 0;
    int   stall_seen  = 0;
    int   rx_hold     = 0;
    logic pix_beat    = 1'b0;

    // Statistics
    int err_cnt     = 0;
    int pixels_in   = 0;
    int beats_out   = 0;
    int hits        = 0;
    int frames      = 0;
    int quiet_cycles = 0;

    // Shadow of the block: registers, line stores, window, raster position
    logic [10:0]        cfg_width  = RST_WIDTH;
    logic [10:0]        cfg_height = RST_HEIGHT;
    logic               cfg_inner  = RST_INNER;
    bit                 older_row [DEF_MAX_COLS];
    bit                 newer_row [DEF_MAX_COLS];
    logic [8:0]         window  = '0;
    logic [COORD_W-1:0] col_pos = '0;
    logic [COORD_W-1:0] row_pos = '0;

    function automatic logic [10:0] fit_size(input logic [10:0] v, input int hi);
        if (v < 11'd3)
            return 11'd3;
        if (v > hi)
            return hi[10:0];
        return v;
    endfunction

    // Advance the shadow by one pixel and queue the beat it should produce
    function automatic void trace_boundary(input logic px);
        logic [10:0] w;
        logic [10:0] h;
        logic        top;
        logic        mid;
        logic        hit;
        logic        last_col;
        logic        last_pix;
        t_boundary   res;
        w   = fit_size(cfg_width, DEF_MAX_COLS);
        h   = fit_size(cfg_height, DEF_MAX_ROWS);
        top = older_row[col_pos];
        mid = newer_row[col_pos];
        older_row[col_pos] = mid;
        newer_row[col_pos] = px;
        // columns shift left; newest column is bits [2:0] = {bottom, mid, top}
        window = {window[5:0], px, mid, top};
        hit = 1'b0;
        if (col_pos >= 2 && row_pos >= 2) begin
            if (cfg_inner)
                hit = window[4] && !(window[1] && window[3] && window[5] && window[7]);
            else
                hit = !window[4] && (window[1] || window[3] || window[5] || window[7]);
        end
        last_col = ({1'b0, col_pos} >= w - 11'd1);
        last_pix = last_col && ({1'b0, row_pos} >= h - 11'd1);
        res.col        = hit ? col_pos - 10'd1 : '0;
        res.row        = hit ? row_pos - 10'd1 : '0;
        res.found      = hit;
        res.frame_done = last_pix;
        if (hit || last_pix)
            boundary_q = {boundary_q, res};
        if (last_col) begin
            col_pos = '0;
            row_pos = last_pix ? '0 : row_pos + 10'd1;
        end else begin
            col_pos = col_pos + 10'd1;
        end
    endfunction

    // Raster-order pixels of one frame
    function automatic void queue_frame(input int w, input int h, input t_mask_pattern pat);
        int x0 [2];
        int x1 [2];
        int y0 [2];
        int y1 [2];
        int density;
        bit invert;
        bit in_rect;
        bit px;
        for (int k = 0; k < 2; k++) begin
            x0[k] = $urandom_range(w - 1);
            x1[k] = $urandom_range(w - 1, x0[k]);
            y0[k] = $urandom_range(h - 1);
            y1[k] = $urandom_range(h - 1, y0[k]);
        end
        density = $urandom_range(100);
        invert  = 1'($urandom_range(1));
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                in_rect = 1'b0;
                for (int k = 0; k < 2; k++)
                    in_rect |= (x >= x0[k] && x <= x1[k] && y >= y0[k] && y <= y1[k]);
                case (pat)
                    PAT_EMPTY:   px = 1'b0;
                    PAT_FULL:    px = 1'b1;
                    PAT_CHECKER: px = 1'((x + y) % 2);
                    PAT_BLOB:    px = in_rect ^ invert;
                    default:     px = ($urandom_range(99) < density);
                endcase
                pix_q = {pix_q, px};
            end
        end
    endfunction

    // 3x3 frame, bit 0 is the first pixel in raster order
    function automatic void queue_tile3(input logic [8:0] bits);
        for (int i = 0; i < 9; i++)
            pix_q = {pix_q, bits[i]};
    endfunction

    function automatic logic [10:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 11'($urandom_range(2));
        if (r < 15)
            return 11'($urandom_range(16, 13));
        return 11'($urandom_range(12, 3));
    endfunction

    function automatic t_mask_pattern pick_pattern();
        int r;
        r = $urandom_range(99);
        if (r < 65) return PAT_BLOB;
        if (r < 80) return PAT_NOISE;
        if (r < 90) return PAT_CHECKER;
        if (r < 95) return PAT_EMPTY;
        return PAT_FULL;
    endfunction

    // APB write: setup cycle, access cycle; shadow follows the written word
    task automatic cfg_write(input logic [1:0] idx, input logic [10:0] value);
        logic [31:0] word;
        word       = $urandom();
        word[10:0] = value;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = word[10:0];
            REG_HEIGHT: cfg_height = word[10:0];
            REG_MODE:   cfg_inner  = word[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Wait until all pixels are taken and every expected beat has arrived
    task automatic settle();
        @(posedge i_clk);
        while (pix_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        @(negedge i_clk);
        while (boundary_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Pixel driver: a new beat only once the previous one is taken
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || pix_beat) begin
            if (i_rst_n && !tx_pause && pix_q.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct) begin
                s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, pix_q.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: random back-pressure, or a long hold when kicked
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_kick != stall_seen) begin
            stall_seen    <= stall_kick;
            rx_hold       <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predict on pixel beats, check result beats, watchdog
    always @(posedge i_clk) begin : beat_monitor
        t_boundary want;
        logic      in_beat;
        logic      out_beat;
        in_beat  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_beat = i_rst_n && m_axis_tvalid && m_axis_tready;
        pix_beat <= in_beat;
        if (in_beat) begin
            trace_boundary(s_axis_tdata[0]);
            pixels_in++;
        end
        if (out_beat) begin
            beats_out++;
            if (boundary_q.size() == 0) begin
                $error("result beat with nothing expected: col %0d row %0d found %0b done %0b",
                       m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tuser, m_axis_tlast);
                err_cnt++;
            end else begin
                want = boundary_q.pop_front();
                if (m_axis_tdata[9:0] !== want.col) begin
                    $error("col: expected %0d, got %0d", want.col, m_axis_tdata[9:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[19:10] !== want.row) begin
                    $error("row: expected %0d, got %0d", want.row, m_axis_tdata[19:10]);
                    err_cnt++;
                end
                if (m_axis_tuser !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, m_axis_tuser);
                    err_cnt++;
                end
                if (m_axis_tlast !== want.frame_done) begin
                    $error("frame_done: expected %0b, got %0b", want.frame_done, m_axis_tlast);
                    err_cnt++;
                end
                hits   += int'(want.found);
                frames += int'(want.frame_done);
            end
        end
        if (!i_rst_n || in_beat || out_beat) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, boundary_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Test sequence
    initial begin
        int            sent;
        int            goal;
        int            c;
        int            r;
        int            w_eff;
        int            h_eff;
        int            left;
        int            n_frames;
        bit            last_col;
        bit            done;
        t_mask_pattern pat;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Smallest frames; sizes below 3 clamp to 3
        cfg_write(REG_WIDTH, 11'd0);
        cfg_write(REG_HEIGHT, 11'd2);
        cfg_write(REG_MODE, 11'd0);
        queue_tile3(9'b111_101_111);     // empty centre ringed by filled: outer hit
        settle();
        cfg_write(REG_HEIGHT, 11'd1);
        cfg_write(REG_MODE, 11'd1);
        queue_tile3(9'b000_010_000);     // isolated filled centre: inner hit
        queue_tile3(9'b111_111_111);     // no boundary: frame-done beat only

        // Oversize width clamps to the store depth: one full row, then part of the next
        settle();
        cfg_write(REG_WIDTH, 11'h7FF);
        cfg_write(REG_HEIGHT, 11'd3);
        cfg_write(REG_MODE, 11'd0);
        for (int i = 0; i < DEF_MAX_COLS + 5; i++)
            pix_q = {pix_q, 1'($urandom_range(1))};

        // Shrink both sizes mid-frame: the column counter past the new end wraps
        settle();
        cfg_write(REG_WIDTH, 11'd4);
        cfg_write(REG_HEIGHT, 11'd5);
        cfg_write(REG_MODE, 11'd1);
        c     = int'(col_pos);
        r     = int'(row_pos);
        w_eff = int'(fit_size(cfg_width, DEF_MAX_COLS));
        h_eff = int'(fit_size(cfg_height, DEF_MAX_ROWS));
        left  = 0;
        do begin
            left++;
            last_col = (c >= w_eff - 1);
            done     = last_col && (r >= h_eff - 1);
            if (last_col) begin
                c = 0;
                r++;
            end else begin
                c++;
            end
        end while (!done);
        for (int i = 0; i < left; i++)
            pix_q = {pix_q, 1'($urandom_range(1))};

        // Random frames in groups sharing one register setting, three traffic phases
        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            settle();
            case (ph)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 49;
                end
                1: begin
                    tx_idle_pct = 49;
                    rx_idle_pct = 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            goal = sent + PHASE_PIXELS;

            if (ph == 2) begin
                // Receiver holds off while a dense frame streams in
                cfg_write(REG_WIDTH, 11'd6);
                cfg_write(REG_HEIGHT, 11'd6);
                cfg_write(REG_MODE, 11'd0);
                stall_kick++;
                queue_frame(6, 6, PAT_CHECKER);
                sent += 36;

                // Sender stops mid-frame until every result is out
                settle();
                cfg_write(REG_WIDTH, 11'd6);
                cfg_write(REG_HEIGHT, 11'd6);
                cfg_write(REG_MODE, 11'($urandom_range(1)));
                queue_frame(6, 6, PAT_BLOB);
                sent += 36;
                @(posedge i_clk);
                while (pix_q.size() > 18)
                    @(posedge i_clk);
                tx_pause = 1'b1;
                @(negedge i_clk);
                while (s_axis_tvalid || boundary_q.size() != 0)
                    @(negedge i_clk);
                @(posedge i_clk);
                tx_pause = 1'b0;
            end

            while (sent < goal) begin
                settle();
                cfg_write(REG_WIDTH, pick_size());
                cfg_write(REG_HEIGHT, pick_size());
                cfg_write(REG_MODE, 11'($urandom_range(1)));
                w_eff    = int'(fit_size(cfg_width, DEF_MAX_COLS));
                h_eff    = int'(fit_size(cfg_height, DEF_MAX_ROWS));
                n_frames = $urandom_range(2, 1);
                for (int f = 0; f < n_frames; f++) begin
                    pat = pick_pattern();
                    queue_frame(w_eff, h_eff, pat);
                    sent += w_eff * h_eff;
                end
            end
        end

        settle();
        $display("Streamed %0d mask pixels in %0d frames; %0d result beats, %0d boundary hits.",
                 pixels_in, frames, beats_out, hits);
        $display("Both modes, undersized and oversized sizes, a mid-frame resize, long stalls.");
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
